// ===== sv/jsu_pkg.sv =====
// package for the json string unescaper: decode modes, result and error codes,
// the utf-8 checker state and its step function, and the utf-8 encoder
// no dependencies
package jsu_pkg;

    typedef enum logic [3:0] {
        MODE_WAIT   = 4'd0,
        MODE_STR    = 4'd1,
        MODE_ESC    = 4'd2,
        MODE_HEX1   = 4'd3,
        MODE_NEEDBS = 4'd4,
        MODE_NEEDU  = 4'd5,
        MODE_HEX2   = 4'd6,
        MODE_SKIP   = 4'd7
    } mode_t;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE    = 4'd1;
    localparam logic [3:0] ERR_CONTROL     = 4'd2;
    localparam logic [3:0] ERR_BAD_ESC     = 4'd3;
    localparam logic [3:0] ERR_TRUNC_ESC   = 4'd4;
    localparam logic [3:0] ERR_TRUNC_UNI   = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX     = 4'd6;
    localparam logic [3:0] ERR_LONE_HIGH   = 4'd7;
    localparam logic [3:0] ERR_BAD_LOW     = 4'd8;
    localparam logic [3:0] ERR_LONE_LOW    = 4'd9;
    localparam logic [3:0] ERR_BAD_UTF8    = 4'd10;
    localparam logic [3:0] ERR_UNTERM      = 4'd11;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] RANGE_FULL = 3'd0;
    localparam logic [2:0] RANGE_A0BF = 3'd1;
    localparam logic [2:0] RANGE_809F = 3'd2;
    localparam logic [2:0] RANGE_90BF = 3'd3;
    localparam logic [2:0] RANGE_808F = 3'd4;

    typedef struct packed {
        logic [1:0] pending;
        logic [2:0] range_cls;
        logic       invalid;
    } u8_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] err;
    } res_t;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } enc_t;

    function automatic u8_t utf8_feed(u8_t s, logic [7:0] b);
        u8_t        r;
        logic [7:0] lo;
        logic [7:0] hi;
        r  = s;
        lo = 8'h80;
        hi = 8'hbf;
        if (s.pending != 2'd0)
        begin
            priority case (s.range_cls)
                RANGE_A0BF: lo = 8'ha0;
                RANGE_809F: hi = 8'h9f;
                RANGE_90BF: lo = 8'h90;
                RANGE_808F: hi = 8'h8f;
                default:    lo = 8'h80;
            endcase
            if (b >= lo && b <= hi)
            begin
                r.pending = s.pending - 2'd1;
            end
            else
            begin
                r.invalid = 1'b1;
                r.pending = 2'd0;
            end
            r.range_cls = RANGE_FULL;
        end
        else if (b <= 8'h7f)
        begin
            r = s;
        end
        else if (b >= 8'hc2 && b <= 8'hdf)
        begin
            r.pending   = 2'd1;
            r.range_cls = RANGE_FULL;
        end
        else if (b == 8'he0)
        begin
            r.pending   = 2'd2;
            r.range_cls = RANGE_A0BF;
        end
        else if (b == 8'hed)
        begin
            r.pending   = 2'd2;
            r.range_cls = RANGE_809F;
        end
        else if (b >= 8'he1 && b <= 8'hef)
        begin
            r.pending   = 2'd2;
            r.range_cls = RANGE_FULL;
        end
        else if (b == 8'hf0)
        begin
            r.pending   = 2'd3;
            r.range_cls = RANGE_90BF;
        end
        else if (b >= 8'hf1 && b <= 8'hf3)
        begin
            r.pending   = 2'd3;
            r.range_cls = RANGE_FULL;
        end
        else if (b == 8'hf4)
        begin
            r.pending   = 2'd3;
            r.range_cls = RANGE_808F;
        end
        else
        begin
            r.invalid = 1'b1;
        end
        return r;
    endfunction

    function automatic enc_t utf8_encode(logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp <= 21'h7f)
        begin
            e.cnt      = 3'd1;
            e.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h7ff)
        begin
            e.cnt      = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hffff)
        begin
            e.cnt      = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            e.cnt      = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ===== sv/jsu_if.sv =====
// valid/ready channel interfaces for the json string unescaper:
// the byte input channel and the result output channel
// no dependencies
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_end;

    modport source (output valid, output in_byte, output line_end, input ready);
    modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [3:0] error_code;
    logic       last;

    modport source (output valid, output result_kind, output out_byte,
                    output error_code, output last, input ready);
    modport sink (input valid, input result_kind, input out_byte,
                  input error_code, input last, output ready);
endinterface

// ===== sv/json_string_unescape_utf8.sv =====
// json string unescaper: line bytes in, decoded utf-8 bytes and status out
// depends on jsu_pkg and the channel interfaces in jsu_if.sv
// latency: first result of an item is offered the cycle after its transfer
// throughput: one item per cycle while out_ch is ready; an item decoding to n results holds input
//   until the single result port has drained the last of them from the 4-entry buffer
// reset: rst_n asynchronous active low, decoder waits for an opening quote
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    jsu_in_if.sink            in_ch,
    jsu_out_if.source         out_ch
);

    mode_t       mode_reg, mode_next;
    logic [15:0] acc_reg, acc_next;
    logic [2:0]  pos_reg, pos_next;
    logic        bad_reg, bad_next;
    logic [9:0]  high_reg, high_next;
    u8_t         u8_reg, u8_next;

    res_t        res_reg [4];
    res_t        res_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  rd_reg;

    logic        in_xfer;
    logic        out_xfer;
    logic        out_last;

    logic        term;
    res_t        term_res;
    enc_t        dat;
    logic [7:0]  b;
    logic [3:0]  digit;
    logic        is_hex;
    logic [15:0] acc_new;
    logic [2:0]  pos_new;
    logic        bad_new;
    logic [20:0] cp;
    u8_t         u8_tmp;

    assign out_ch.valid       = (cnt_reg != 3'd0);
    assign out_ch.result_kind = res_reg[rd_reg].kind;
    assign out_ch.out_byte    = res_reg[rd_reg].data;
    assign out_ch.error_code  = res_reg[rd_reg].err;
    assign out_last           = ({1'b0, rd_reg} == (cnt_reg - 3'd1));
    assign out_ch.last        = out_last;
    assign out_xfer           = out_ch.valid && out_ch.ready;
    assign in_ch.ready        = (cnt_reg == 3'd0) || (out_xfer && out_last);
    assign in_xfer            = in_ch.valid && in_ch.ready;

    always_comb
    begin
        b         = in_ch.in_byte;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        bad_next  = bad_reg;
        high_next = high_reg;
        u8_next   = u8_reg;
        term      = 1'b0;
        term_res  = '{kind: KIND_ERR, data: 8'd0, err: ERR_NONE};
        dat       = '0;
        cp        = '0;
        is_hex    = 1'b1;
        digit     = 4'd0;

        if (b >= 8'h30 && b <= 8'h39)
        begin
            digit = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            digit = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            digit = 4'(b - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
        acc_new = {acc_reg[11:0], digit};
        pos_new = pos_reg + 3'd1;
        bad_new = bad_reg || !is_hex;

        if (in_ch.line_end)
        begin
            mode_next = MODE_WAIT;
            unique case (mode_reg)
                MODE_STR:
                begin
                    term         = 1'b1;
                    term_res.err = ERR_UNTERM;
                end
                MODE_ESC:
                begin
                    term         = 1'b1;
                    term_res.err = ERR_TRUNC_ESC;
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    term         = 1'b1;
                    term_res.err = ERR_TRUNC_UNI;
                end
                MODE_NEEDBS, MODE_NEEDU:
                begin
                    term         = 1'b1;
                    term_res.err = ERR_LONE_HIGH;
                end
                default:
                begin
                    term = 1'b0;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_WAIT:
                begin
                    if (b == CH_QUOTE)
                    begin
                        acc_next  = '0;
                        pos_next  = '0;
                        bad_next  = 1'b0;
                        high_next = '0;
                        u8_next   = '0;
                        mode_next = MODE_STR;
                    end
                    else
                    begin
                        term         = 1'b1;
                        term_res.err = ERR_NO_QUOTE;
                        mode_next    = MODE_SKIP;
                    end
                end
                MODE_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        term      = 1'b1;
                        mode_next = MODE_WAIT;
                        if (u8_reg.invalid || u8_reg.pending != 2'd0)
                        begin
                            term_res.err = ERR_BAD_UTF8;
                        end
                        else
                        begin
                            term_res.kind = KIND_DONE;
                        end
                    end
                    else if (b < CH_SPACE)
                    begin
                        term         = 1'b1;
                        term_res.err = ERR_CONTROL;
                        mode_next    = MODE_SKIP;
                    end
                    else if (b == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        dat.cnt      = 3'd1;
                        dat.bytes[0] = b;
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_STR;
                    dat.cnt   = 3'd1;
                    priority case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: dat.bytes[0] = b;
                        8'h62: dat.bytes[0] = 8'h08;
                        8'h66: dat.bytes[0] = 8'h0c;
                        8'h6e: dat.bytes[0] = 8'h0a;
                        8'h72: dat.bytes[0] = 8'h0d;
                        8'h74: dat.bytes[0] = 8'h09;
                        CH_U:
                        begin
                            dat.cnt   = 3'd0;
                            acc_next  = '0;
                            pos_next  = '0;
                            bad_next  = 1'b0;
                            mode_next = MODE_HEX1;
                        end
                        default:
                        begin
                            dat.cnt      = 3'd0;
                            term         = 1'b1;
                            term_res.err = ERR_BAD_ESC;
                            mode_next    = MODE_SKIP;
                        end
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    acc_next = acc_new;
                    pos_next = pos_new;
                    bad_next = bad_new;
                    if (pos_new >= 3'd4)
                    begin
                        if (bad_new)
                        begin
                            term         = 1'b1;
                            term_res.err = ERR_BAD_HEX;
                            mode_next    = MODE_SKIP;
                        end
                        else if (mode_reg == MODE_HEX1)
                        begin
                            if (acc_new >= 16'hd800 && acc_new <= 16'hdbff)
                            begin
                                high_next = acc_new[9:0];
                                mode_next = MODE_NEEDBS;
                            end
                            else if (acc_new >= 16'hdc00 && acc_new <= 16'hdfff)
                            begin
                                term         = 1'b1;
                                term_res.err = ERR_LONE_LOW;
                                mode_next    = MODE_SKIP;
                            end
                            else
                            begin
                                cp        = {5'd0, acc_new};
                                dat       = utf8_encode(cp);
                                mode_next = MODE_STR;
                            end
                        end
                        else
                        begin
                            if (acc_new < 16'hdc00 || acc_new > 16'hdfff)
                            begin
                                term         = 1'b1;
                                term_res.err = ERR_BAD_LOW;
                                mode_next    = MODE_SKIP;
                            end
                            else
                            begin
                                cp        = 21'h10000 + {1'b0, high_reg, acc_new[9:0]};
                                dat       = utf8_encode(cp);
                                mode_next = MODE_STR;
                            end
                        end
                    end
                end
                MODE_NEEDBS:
                begin
                    if (b == CH_BSLASH)
                    begin
                        mode_next = MODE_NEEDU;
                    end
                    else
                    begin
                        term         = 1'b1;
                        term_res.err = ERR_LONE_HIGH;
                        mode_next    = MODE_SKIP;
                    end
                end
                MODE_NEEDU:
                begin
                    if (b == CH_U)
                    begin
                        acc_next  = '0;
                        pos_next  = '0;
                        bad_next  = 1'b0;
                        mode_next = MODE_HEX2;
                    end
                    else
                    begin
                        term         = 1'b1;
                        term_res.err = ERR_LONE_HIGH;
                        mode_next    = MODE_SKIP;
                    end
                end
                default:
                begin
                    mode_next = MODE_SKIP;
                end
            endcase
        end

        // utf-8 check runs over the decoded bytes of this item in order
        u8_tmp = u8_next;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < dat.cnt)
            begin
                u8_tmp = utf8_feed(u8_tmp, dat.bytes[i]);
            end
        end
        u8_next = u8_tmp;

        for (int i = 0; i < 4; i++)
        begin
            res_next[i] = '{kind: KIND_DATA, data: dat.bytes[i], err: ERR_NONE};
        end
        if (term)
        begin
            res_next[0] = term_res;
            cnt_next    = 3'd1;
        end
        else
        begin
            cnt_next = dat.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_WAIT;
            acc_reg  <= '0;
            pos_reg  <= '0;
            bad_reg  <= 1'b0;
            high_reg <= '0;
            u8_reg   <= '0;
            cnt_reg  <= '0;
            rd_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                pos_reg  <= pos_next;
                bad_reg  <= bad_next;
                high_reg <= high_next;
                u8_reg   <= u8_next;
                cnt_reg  <= cnt_next;
                rd_reg   <= '0;
            end
            else if (out_xfer)
            begin
                if (out_last)
                begin
                    cnt_reg <= '0;
                    rd_reg  <= '0;
                end
                else
                begin
                    rd_reg <= rd_reg + 2'd1;
                end
            end
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

// ===== tb/json_string_unescape_utf8_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for json_string_unescape_utf8: directed and random lines
// go in, and every result is checked against an in-bench decoder of the same format
// depends on jsu_pkg (sv/jsu_pkg.sv), jsu_in_if/jsu_out_if (sv/jsu_if.sv) and the rtl
module json_string_unescape_utf8_test;
    import jsu_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] err;
        logic       last;
    } result_t;

    logic clk;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // decoder state
    mode_t       dec_mode;
    logic [15:0] quad_value;
    logic [2:0]  quad_digits;
    logic        quad_bad;
    logic [9:0]  high_half;
    logic [1:0]  u8_left;
    logic [2:0]  u8_class;
    logic        u8_bad;

    result_t    step_results [$];
    result_t    due_results [$];
    logic [7:0] line_q [$];

    bit src_idle;
    bit snk_idle;
    int items_sent;
    int results_seen;
    int strings_ok;
    int strings_err;
    int mismatches;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
        $display("json_string_unescape_utf8_test failed");
        $finish;
    end

    function automatic void clear_decoder();
        dec_mode    = MODE_WAIT;
        quad_value  = 16'h0000;
        quad_digits = 3'd0;
        quad_bad    = 1'b0;
        high_half   = 10'd0;
        u8_left     = 2'd0;
        u8_class    = RANGE_FULL;
        u8_bad      = 1'b0;
    endfunction

    function automatic bit hex_value(input logic [7:0] b, output logic [3:0] d);
        d = 4'd0;
        if (b >= "0" && b <= "9")
        begin
            d = b - "0";
            return 1'b1;
        end
        if (b >= "a" && b <= "f")
        begin
            d = b - "a" + 8'd10;
            return 1'b1;
        end
        if (b >= "A" && b <= "F")
        begin
            d = b - "A" + 8'd10;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int utf8_bytes(input logic [20:0] cp, output logic [7:0] seq [0:3]);
        seq = '{default: 8'h00};
        if (cp < 21'h80)
        begin
            seq[0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800)
        begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000)
        begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            return 3;
        end
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    // strict utf-8 tracking over the decoded bytes of the open string
    function automatic void track_utf8(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hbf;
        if (u8_left != 2'd0)
        begin
            case (u8_class)
                RANGE_A0BF: lo = 8'ha0;
                RANGE_809F: hi = 8'h9f;
                RANGE_90BF: lo = 8'h90;
                RANGE_808F: hi = 8'h8f;
                default: ;
            endcase
            if (b >= lo && b <= hi)
            begin
                u8_left = u8_left - 2'd1;
            end
            else
            begin
                u8_bad  = 1'b1;
                u8_left = 2'd0;
            end
            u8_class = RANGE_FULL;
        end
        else if (b >= 8'h80)
        begin
            if (b >= 8'hc2 && b <= 8'hdf)
            begin
                u8_left  = 2'd1;
                u8_class = RANGE_FULL;
            end
            else if (b >= 8'he0 && b <= 8'hef)
            begin
                u8_left  = 2'd2;
                u8_class = (b == 8'he0) ? RANGE_A0BF : (b == 8'hed) ? RANGE_809F : RANGE_FULL;
            end
            else if (b >= 8'hf0 && b <= 8'hf4)
            begin
                u8_left  = 2'd3;
                u8_class = (b == 8'hf0) ? RANGE_90BF : (b == 8'hf4) ? RANGE_808F : RANGE_FULL;
            end
            else
            begin
                u8_bad = 1'b1;
            end
        end
    endfunction

    function automatic void put_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [3:0] err);
        result_t r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void put_data(input logic [7:0] b);
        track_utf8(b);
        put_result(KIND_DATA, b, ERR_NONE);
    endfunction

    function automatic void put_code(input logic [20:0] cp);
        logic [7:0] seq [0:3];
        int         n;
        n = utf8_bytes(cp, seq);
        for (int i = 0; i < n; i++)
            put_data(seq[i]);
    endfunction

    function automatic void put_error(input logic [3:0] code, input mode_t next_mode);
        put_result(KIND_ERR, 8'h00, code);
        dec_mode = next_mode;
    endfunction

    function automatic void start_quad(input mode_t m);
        quad_value  = 16'h0000;
        quad_digits = 3'd0;
        quad_bad    = 1'b0;
        dec_mode    = m;
    endfunction

    function automatic void quad_step(input logic [7:0] b);
        logic [3:0] d;
        if (!hex_value(b, d))
            quad_bad = 1'b1;
        quad_value  = {quad_value[11:0], d};
        quad_digits = quad_digits + 3'd1;
        if (quad_digits < 3'd4)
            return;
        if (quad_bad)
        begin
            put_error(ERR_BAD_HEX, MODE_SKIP);
            return;
        end
        if (dec_mode == MODE_HEX1)
        begin
            if (quad_value >= 16'hd800 && quad_value <= 16'hdbff)
            begin
                high_half = quad_value[9:0];
                dec_mode  = MODE_NEEDBS;
            end
            else if (quad_value >= 16'hdc00 && quad_value <= 16'hdfff)
            begin
                put_error(ERR_LONE_LOW, MODE_SKIP);
            end
            else
            begin
                put_code({5'd0, quad_value});
                dec_mode = MODE_STR;
            end
        end
        else if (quad_value < 16'hdc00 || quad_value > 16'hdfff)
        begin
            put_error(ERR_BAD_LOW, MODE_SKIP);
        end
        else
        begin
            put_code(21'h10000 + {1'b0, high_half, quad_value[9:0]});
            dec_mode = MODE_STR;
        end
    endfunction

    // works out the results of one accepted transfer and queues them
    function automatic void decode_step(input logic [7:0] b, input logic le);
        result_t r;
        step_results.delete();
        if (le)
        begin
            case (dec_mode)
                MODE_STR:                put_error(ERR_UNTERM, MODE_WAIT);
                MODE_ESC:                put_error(ERR_TRUNC_ESC, MODE_WAIT);
                MODE_HEX1, MODE_HEX2:    put_error(ERR_TRUNC_UNI, MODE_WAIT);
                MODE_NEEDBS, MODE_NEEDU: put_error(ERR_LONE_HIGH, MODE_WAIT);
                default:                 dec_mode = MODE_WAIT;
            endcase
        end
        else
        begin
            case (dec_mode)
                MODE_WAIT:
                begin
                    if (b == CH_QUOTE)
                    begin
                        clear_decoder();
                        dec_mode = MODE_STR;
                    end
                    else
                    begin
                        put_error(ERR_NO_QUOTE, MODE_SKIP);
                    end
                end
                MODE_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        if (u8_bad || u8_left != 2'd0)
                        begin
                            put_error(ERR_BAD_UTF8, MODE_WAIT);
                        end
                        else
                        begin
                            put_result(KIND_DONE, 8'h00, ERR_NONE);
                            dec_mode = MODE_WAIT;
                        end
                    end
                    else if (b < CH_SPACE)
                        put_error(ERR_CONTROL, MODE_SKIP);
                    else if (b == CH_BSLASH)
                        dec_mode = MODE_ESC;
                    else
                        put_data(b);
                end
                MODE_ESC:
                begin
                    dec_mode = MODE_STR;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: put_data(b);
                        "b":     put_data(8'h08);
                        "f":     put_data(8'h0c);
                        "n":     put_data(8'h0a);
                        "r":     put_data(8'h0d);
                        "t":     put_data(8'h09);
                        CH_U:    start_quad(MODE_HEX1);
                        default: put_error(ERR_BAD_ESC, MODE_SKIP);
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                    quad_step(b);
                MODE_NEEDBS:
                begin
                    if (b == CH_BSLASH)
                        dec_mode = MODE_NEEDU;
                    else
                        put_error(ERR_LONE_HIGH, MODE_SKIP);
                end
                MODE_NEEDU:
                begin
                    if (b == CH_U)
                        start_quad(MODE_HEX2);
                    else
                        put_error(ERR_LONE_HIGH, MODE_SKIP);
                end
                default:
                    dec_mode = MODE_SKIP;
            endcase
        end
        if (step_results.size() > 0)
        begin
            r = step_results[step_results.size() - 1];
            r.last = 1'b1;
            step_results[step_results.size() - 1] = r;
        end
        foreach (step_results[i])
            due_results.push_back(step_results[i]);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic le);
        int gap;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.in_byte  <= $urandom;
            in_ch.line_end <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.line_end <= le;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        decode_step(b, le);
        items_sent++;
    endtask

    task automatic end_line();
        send_item($urandom, 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_quoted(input logic [7:0] body [$]);
        send_item(CH_QUOTE, 1'b0);
        foreach (body[i])
            send_item(body[i], 1'b0);
        send_item(CH_QUOTE, 1'b0);
        end_line();
    endtask

    // random content generators
    function automatic logic [7:0] printable();
        logic [7:0] b;
        do
            b = $urandom_range(8'h20, 8'h7e);
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        logic [3:0] d;
        do
            b = $urandom;
        while (hex_value(b, d));
        return b;
    endfunction

    function automatic logic [15:0] random_bmp();
        logic [15:0] v;
        case ($urandom_range(0, 2))
            0: v = $urandom_range(16'h0000, 16'h007f);
            1: v = $urandom_range(16'h0080, 16'h07ff);
            default:
            begin
                do
                    v = $urandom_range(16'h0800, 16'hffff);
                while (v >= 16'hd800 && v <= 16'hdfff);
            end
        endcase
        return v;
    endfunction

    function automatic void add_uescape(input logic [15:0] v);
        logic [3:0] d;
        line_q.push_back(CH_BSLASH);
        line_q.push_back(CH_U);
        for (int i = 3; i >= 0; i--)
        begin
            d = v[4 * i +: 4];
            if (d < 4'd10)
                line_q.push_back("0" + d);
            else
                line_q.push_back(($urandom_range(0, 1) ? "a" : "A") + d - 8'd10);
        end
    endfunction

    function automatic void add_broken_unicode();
        logic [7:0] b;
        logic [15:0] high;
        high = 16'hd800 | $urandom_range(0, 16'h3ff);
        case ($urandom_range(0, 4))
            0:
            begin
                add_uescape($urandom);
                line_q[line_q.size() - 1 - $urandom_range(0, 3)] = non_hex();
            end
            1: add_uescape(16'hdc00 | $urandom_range(0, 16'h3ff));
            2:
            begin
                add_uescape(high);
                line_q.push_back(printable());
            end
            3:
            begin
                add_uescape(high);
                line_q.push_back(CH_BSLASH);
                do
                    b = $urandom;
                while (b == CH_U);
                line_q.push_back(b);
            end
            default:
            begin
                add_uescape(high);
                add_uescape($urandom_range(0, 1) ? random_bmp() : high);
            end
        endcase
    endfunction

    function automatic void add_token();
        logic [7:0]  esc_chars [0:7];
        logic [7:0]  seq [0:3];
        logic [19:0] v;
        logic [20:0] cp;
        int          n;
        int          pick;
        esc_chars = '{CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t"};
        pick = $urandom_range(0, 19);
        if (pick <= 6 || pick == 19)
        begin
            line_q.push_back(printable());
        end
        else if (pick <= 8)
        begin
            case ($urandom_range(0, 2))
                0: cp = $urandom_range(21'h80, 21'h7ff);
                1: cp = {5'd0, random_bmp()} | 21'h800;
                default: cp = $urandom_range(21'h10000, 21'h10ffff);
            endcase
            if (cp >= 21'hd800 && cp <= 21'hdfff)
                cp = cp ^ 21'h4000;
            n = utf8_bytes(cp, seq);
            for (int i = 0; i < n; i++)
                line_q.push_back(seq[i]);
        end
        else if (pick <= 10)
        begin
            line_q.push_back(CH_BSLASH);
            line_q.push_back(esc_chars[$urandom_range(0, 7)]);
        end
        else if (pick <= 13)
        begin
            add_uescape(random_bmp());
        end
        else if (pick <= 15)
        begin
            v = $urandom;
            add_uescape({6'b110110, v[19:10]});
            add_uescape({6'b110111, v[9:0]});
        end
        else if (pick == 16)
        begin
            line_q.push_back($urandom);
        end
        else if (pick == 17)
        begin
            line_q.push_back(CH_BSLASH);
            line_q.push_back($urandom);
        end
        else
        begin
            add_broken_unicode();
        end
    endfunction

    task automatic random_line();
        int cut;
        line_q.delete();
        if ($urandom_range(0, 15) == 0)
            line_q.push_back($urandom);
        else
            line_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) add_token();
        case ($urandom_range(0, 9))
            0: ;
            1:
            begin
                line_q.push_back(CH_QUOTE);
                add_token();
            end
            default: line_q.push_back(CH_QUOTE);
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(0, line_q.size() - 1);
            while (line_q.size() > cut)
                line_q.delete(line_q.size() - 1);
        end
        if ($urandom_range(0, 3) == 0)
            src_idle = $urandom_range(0, 1);
        if ($urandom_range(0, 3) == 0)
            snk_idle = $urandom_range(0, 1);
        foreach (line_q[i])
            send_item(line_q[i], 1'b0);
        end_line();
    endtask

    // test cases
    task automatic test_plain_bytes();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        send_text("\"\"");
        end_line();
        send_quoted('{CH_SPACE, 8'h7e, 8'h7f, 8'hc2, 8'hbf, 8'hf4, 8'h8f, 8'hbf, 8'hbf});
    endtask

    task automatic test_short_escapes();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
        end_line();
    endtask

    task automatic test_unicode_escapes();
        send_text("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\ud800\\udc00\\uDBFF\\uDFFF\"");
        end_line();
    endtask

    task automatic test_line_framing();
        send_text("x\"a");
        end_line();
        end_line();
        send_text("\"ok\"y");
        end_line();
        send_text("\"ab");
        end_line();
    endtask

    task automatic test_escape_errors();
        send_quoted('{8'h1f});
        send_quoted('{8'h00});
        send_text("\"\\q\"");
        end_line();
        send_text("\"\\");
        end_line();
        send_text("\"\\u12");
        end_line();
        send_text("\"\\uz1");
        end_line();
        send_text("\"\\u12g4\"");
        end_line();
    endtask

    task automatic test_surrogate_errors();
        send_text("\"\\udc00\"");
        end_line();
        send_text("\"\\ud800x");
        end_line();
        send_text("\"\\ud800\\n");
        end_line();
        send_text("\"\\ud800");
        end_line();
        send_text("\"\\ud800\\");
        end_line();
        send_text("\"\\ud800\\u0041\"");
        end_line();
        send_text("\"\\ud800\\udc");
        end_line();
    endtask

    task automatic test_utf8_validation();
        send_quoted('{8'hc0, 8'h80});
        send_quoted('{8'he0, 8'h80, 8'h80});
        send_quoted('{8'hed, 8'ha0, 8'h80});
        send_quoted('{8'hf4, 8'h90, 8'h80, 8'h80});
        send_quoted('{8'he2, 8'h82});
        send_quoted('{8'hff});
        send_quoted('{8'h80});
        send_quoted('{8'he0, 8'ha0, 8'h80, 8'hf0, 8'h90, 8'h80, 8'h80});
    endtask

    task automatic test_random_lines();
        int start;
        start = items_sent;
        while (items_sent - start < 160)
            random_line();
    endtask

    // result checker
    initial
    begin : result_check
        int      stall;
        result_t got;
        result_t want;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            got.kind = out_ch.result_kind;
            got.data = out_ch.out_byte;
            got.err  = out_ch.error_code;
            got.last = out_ch.last;
            results_seen++;
            if (got.kind == KIND_DONE)
                strings_ok++;
            if (got.kind == KIND_ERR)
                strings_err++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got kind %0d byte %h err %0d last %0b",
                         $time, got.kind, got.data, got.err, got.last);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.err !== want.err || got.last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: mismatch, expected kind %0d byte %h err %0d last %0b, got kind %0d byte %h err %0d last %0b",
                             $time, want.kind, want.data, want.err, want.last,
                             got.kind, got.data, got.err, got.last);
                end
            end
        end
    end

    initial
    begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
        items_sent   = 0;
        results_seen = 0;
        strings_ok   = 0;
        strings_err  = 0;
        mismatches   = 0;
        clear_decoder();
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= 8'h00;
        in_ch.line_end <= 1'b0;
        rst_n          <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_short_escapes();
        test_unicode_escapes();
        test_line_framing();
        test_escape_errors();
        test_surrogate_errors();
        test_utf8_validation();
        test_random_lines();

        in_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d byte and line-end transfers, checked %0d result transfers",
                 items_sent, results_seen);
        $display("strings closed cleanly: %0d, errors reported: %0d", strings_ok, strings_err);
        if (mismatches == 0)
            $display("json_string_unescape_utf8_test passed");
        else
            $display("json_string_unescape_utf8_test failed");
        $finish;
    end

endmodule
